### design/crm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_pkg: shared types and constants for the corner response measure
// Widths, mode codes and register indexes shared by all modules.
// ----------------------------------------------------------------------------
package crm_pkg;
    localparam int CoefWidth = 24;
    localparam int RespWidth = 48;
    localparam int SqrtWidth = CoefWidth + 2;      // root of a value below 2^(2W+2)
    localparam int DiscWidth = 2 * CoefWidth + 2;  // (A-C)^2 + 4B^2

    // Harris numerator det*2^16 - k*trace^2 in Q.16, signed
    localparam int HarrisWidth = 2 * CoefWidth + 20;
    // harmonic divider: 2*|det| over trace + 1
    localparam int DivNumWidth = 2 * CoefWidth + 2;
    localparam int DivDenWidth = CoefWidth + 1;
    // Harris value, det sign, trace and last flag carried beside the divider
    localparam int DivTagWidth = HarrisWidth + CoefWidth + 3;

    typedef enum logic [1:0] {
        MODE_HARRIS   = 2'd0,
        MODE_HARMONIC = 2'd1,
        MODE_SHI      = 2'd2,
        MODE_UNUSED   = 2'd3
    } t_mode;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_K      = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;
endpackage

### design/crm_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_sqrt: pipelined integer square root
// One result bit per stage, restoring method, one item may enter each cycle while enabled.
// All stages advance together and hold while the enable is low.
// ----------------------------------------------------------------------------
module crm_sqrt (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [crm_pkg::DiscWidth-1:0]     i_rad,
    output logic [crm_pkg::SqrtWidth-1:0]     o_root
);
    localparam int N  = crm_pkg::SqrtWidth;
    localparam int RW = N + 2;

    logic [N:0][2*N-1:0]                 r_rad;
    logic [N:0][RW-1:0]                  r_rem;
    logic [N:0][N-1:0]                   r_root;

    // stage zero captures the input
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= (2*N)'(i_rad);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // one root bit per stage
    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [RW-1:0] n_trial;
        logic [RW-1:0] n_rem;
        logic [RW-1:0] n_sub;
        always_comb begin
            n_trial = {r_rem[g][RW-3:0], r_rad[g][2*N-1 -: 2]};
            n_sub   = RW'({r_root[g], 2'b01});
            n_rem   = n_trial - n_sub;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[g+1] <= {r_rad[g][2*N-3:0], 2'b00};
                if (n_trial >= n_sub) begin
                    r_rem[g+1]  <= n_rem;
                    r_root[g+1] <= {r_root[g][N-2:0], 1'b1};
                end else begin
                    r_rem[g+1]  <= n_trial;
                    r_root[g+1] <= {r_root[g][N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[N];
endmodule

### design/crm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_div: pipelined unsigned divider
// One quotient bit per stage, restoring method; tag travels alongside.
// ----------------------------------------------------------------------------
module crm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [crm_pkg::DivNumWidth-1:0]     i_num,
    input  logic [crm_pkg::DivDenWidth-1:0]     i_den,
    input  logic [crm_pkg::DivTagWidth-1:0]     i_tag,
    output logic                                o_valid,
    output logic [crm_pkg::DivNumWidth-1:0]     o_quo,
    output logic                                o_rem_nz,
    output logic [crm_pkg::DivTagWidth-1:0]     o_tag
);
    localparam int NumWidth = crm_pkg::DivNumWidth;
    localparam int DenWidth = crm_pkg::DivDenWidth;
    localparam int TagWidth = crm_pkg::DivTagWidth;
    localparam int N = NumWidth;

    logic [N:0]                   r_vld;
    logic [N:0][NumWidth-1:0]     r_num;
    logic [N:0][DenWidth-1:0]     r_den;
    logic [N:0][DenWidth-1:0]     r_rem;
    logic [N:0][TagWidth-1:0]     r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= i_num;
            r_den[0] <= i_den;
            r_rem[0] <= '0;
            r_tag[0] <= i_tag;
        end
    end

    // shift in a numerator bit, subtract when it fits; quotient bits
    // replace numerator bits from the bottom
    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [DenWidth:0] n_trial;
        always_comb n_trial = {r_rem[g], r_num[g][N-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g+1] <= r_den[g];
                r_tag[g+1] <= r_tag[g];
                if (n_trial >= {1'b0, r_den[g]}) begin
                    r_rem[g+1] <= DenWidth'(n_trial - {1'b0, r_den[g]});
                    r_num[g+1] <= {r_num[g][N-2:0], 1'b1};
                end else begin
                    r_rem[g+1] <= DenWidth'(n_trial);
                    r_num[g+1] <= {r_num[g][N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid  = r_vld[N];
    assign o_quo    = r_num[N];
    assign o_rem_nz = |r_rem[N];
    assign o_tag    = r_tag[N];
endmodule

### design/corner_response_measure.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// corner_response_measure: Harris / harmonic / Shi-Tomasi corner response
// Per-pixel measure from a smoothed 2x2 structure tensor, thresholded and
// saturated to 48 bits.
// ----------------------------------------------------------------------------
//  channel   dir  fields (tdata from bit 0)                  tuser/tlast
//  s_axis    in   coef_a[23:0] coef_b[47:24] coef_c[71:48]   tlast=last_pixel
//  m_axis    out  response[47:0]                             tlast=last_pixel_out
//  apb       in   0x00 measure_mode, 0x08 harris_k, 0x10 response_threshold
//
// One item per cycle is accepted while the output is not stalled; the result
// reaches m_axis through four operand stages, 51 in the bit-per-stage divider
// of the harmonic path and one output register; the root and all other
// paths are delayed to match. The whole pipeline advances only when the
// output register is empty or being taken, so a stall holds every stage.
// Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module corner_response_measure (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // coef_a, coef_b, coef_c
    input  logic         s_axis_tlast,   // last_pixel
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // response
    output logic         m_axis_tlast,   // last_pixel_out
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    localparam int W   = crm_pkg::CoefWidth;
    localparam int NW  = crm_pkg::DivNumWidth;   // 2*det numerator magnitude
    localparam int DW  = crm_pkg::DivDenWidth;   // trace + 1
    localparam int TW  = 2 * W + 2;              // signed det + sign margin
    localparam int XW  = crm_pkg::HarrisWidth;   // Harris Q.16 width

    // ---------------- configuration ----------------
    logic [1:0]  r_mode;
    logic [15:0] r_k;
    logic [47:0] r_thr;
    logic        n_wr;

    assign pready = 1'b1;
    assign n_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= crm_pkg::MODE_HARRIS;
            r_k    <= 16'd3932;
            r_thr  <= '0;
        end else if (n_wr) begin
            unique case (paddr[4:3])
                crm_pkg::REG_MODE:   r_mode <= pwdata[1:0];
                crm_pkg::REG_K:      r_k    <= pwdata[15:0];
                crm_pkg::REG_THRESH: r_thr  <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            crm_pkg::REG_MODE:   prdata = 64'(r_mode);
            crm_pkg::REG_K:      prdata = 64'(r_k);
            crm_pkg::REG_THRESH: prdata = 64'(r_thr);
            default:             prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic r_ovld;
    logic n_en;
    assign n_en          = !r_ovld || m_axis_tready;
    assign s_axis_tready = n_en;

    // ---------------- stage 1: operands ----------------
    logic          r1_v, r1_l;
    logic [W-1:0]  r1_a, r1_c, r1_bm, r1_d;
    logic [W:0]    r1_tr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (n_en) r1_v <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r1_a  <= s_axis_tdata[W-1:0];
            r1_c  <= s_axis_tdata[48 +: W];
            r1_bm <= s_axis_tdata[24+W-1] ? W'(-s_axis_tdata[24 +: W]) : s_axis_tdata[24 +: W];
            r1_d  <= (s_axis_tdata[W-1:0] > s_axis_tdata[48 +: W])
                     ? W'(s_axis_tdata[W-1:0] - s_axis_tdata[48 +: W])
                     : W'(s_axis_tdata[48 +: W] - s_axis_tdata[W-1:0]);
            r1_tr <= (W+1)'(s_axis_tdata[W-1:0]) + (W+1)'(s_axis_tdata[48 +: W]);
            r1_l  <= s_axis_tlast;
        end
    end

    // ---------------- stage 2: products ----------------
    logic               r2_v, r2_l;
    logic [2*W-1:0]     r2_ac, r2_bb, r2_dd;
    logic [2*W+1:0]     r2_tt;
    logic [W:0]         r2_tr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (n_en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r2_ac <= r1_a * r1_c;
            r2_bb <= r1_bm * r1_bm;
            r2_dd <= r1_d * r1_d;
            r2_tt <= r1_tr * r1_tr;
            r2_tr <= r1_tr;
            r2_l  <= r1_l;
        end
    end

    // ---------------- stage 3: det, disc, k*trace^2 ----------------
    logic                   r3_v, r3_l;
    logic signed [TW-1:0]   r3_det;
    logic [crm_pkg::DiscWidth-1:0] r3_disc;
    logic [2*W+17:0]        r3_kt;
    logic [W:0]             r3_tr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (n_en) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r3_det  <= $signed(TW'(r2_ac)) - $signed(TW'(r2_bb));
            r3_disc <= crm_pkg::DiscWidth'(r2_dd) + {r2_bb, 2'b00};
            r3_kt   <= r2_tt * r_k;
            r3_tr   <= r2_tr;
            r3_l    <= r2_l;
        end
    end

    // ---------------- stage 4: per-mode prep ----------------
    logic signed [XW-1:0]   r4_hx;
    logic [NW-1:0]          r4_num;
    logic                   r4_neg;
    logic [DW-1:0]          r4_den;
    logic                   r4_v, r4_l;
    logic [crm_pkg::DiscWidth-1:0] r4_disc;
    logic [W:0]             r4_tr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (n_en) r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r4_hx   <= ($signed(XW'(r3_det)) <<< 16) - $signed(XW'(r3_kt));
            r4_neg  <= r3_det[TW-1];
            r4_num  <= NW'(r3_det[TW-1] ? -r3_det : r3_det) << 1;
            r4_den  <= DW'(r3_tr) + DW'(1);
            r4_disc <= r3_disc;
            r4_tr   <= r3_tr;
            r4_l    <= r3_l;
        end
    end

    // tag carried through the divider
    localparam int TagW = crm_pkg::DivTagWidth;
    logic [TagW-1:0] n_tag_in;
    assign n_tag_in = {r4_hx, r4_neg, r4_tr, r4_l};

    logic              n_dv, n_rnz;
    logic [NW-1:0]     n_quo;
    logic [TagW-1:0]   n_dtag;
    logic [crm_pkg::SqrtWidth-1:0] n_root;

    crm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(n_en), .i_valid(r4_v),
        .i_num(r4_num), .i_den(r4_den), .i_tag(n_tag_in),
        .o_valid(n_dv), .o_quo(n_quo), .o_rem_nz(n_rnz), .o_tag(n_dtag)
    );

    crm_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(n_en), .i_rad(r4_disc), .o_root(n_root)
    );

    // align root with divider output
    localparam int Gap = NW - crm_pkg::SqrtWidth;
    logic [Gap-1:0][crm_pkg::SqrtWidth-1:0] r_rdl;
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_rdl[0] <= n_root;
            for (int i = 1; i < Gap; i++) r_rdl[i] <= r_rdl[i-1];
        end
    end

    // ---------------- final stage: select, threshold, saturate ----------------
    localparam int RW = XW;
    logic signed [RW-1:0] n_r, n_thr;
    logic signed [RW-1:0] n_hm;
    logic                 n_keep;
    logic signed [XW-1:0] n_hx;
    logic                 n_neg;
    logic [W:0]           n_tr;
    logic [47:0]          n_out;
    logic [crm_pkg::SqrtWidth-1:0] n_s;

    always_comb begin
        n_hx  = n_dtag[TagW-1 -: XW];
        n_neg = n_dtag[W+2];
        n_tr  = n_dtag[W+1:1];
        n_s   = r_rdl[Gap-1];
        n_thr = RW'($signed(r_thr));
        n_hm  = n_neg ? -$signed(RW'(n_quo)) - (n_rnz ? RW'(1) : RW'(0))
                      : $signed(RW'(n_quo));
        case (r_mode)
            crm_pkg::MODE_HARMONIC: begin
                n_r = n_hm;
                n_keep = n_r >= n_thr;
            end
            crm_pkg::MODE_SHI: begin
                n_r = ($signed(RW'(n_tr)) - $signed(RW'(n_s))) >>> 1;
                n_keep = n_r > n_thr;
            end
            default: begin
                n_r = n_hx >>> 24;
                n_keep = n_r >= n_thr;
            end
        endcase
        if (!n_keep) n_r = '0;
        if (n_r > $signed(RW'(48'sh7FFF_FFFF_FFFF))) n_out = 48'h7FFF_FFFF_FFFF;
        else if (n_r < -$signed(RW'(49'sh0_8000_0000_0000))) n_out = 48'h8000_0000_0000;
        else n_out = n_r[47:0];
    end

    logic r_olast;
    logic [47:0] r_odata;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (n_en) r_ovld <= n_dv;
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_odata <= n_out;
            r_olast <= n_dtag[0];
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
endmodule

### design/crm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_port_checks: port-level checks for the corner response measure
// Watches handshakes and configuration port behaviour.
// ----------------------------------------------------------------------------
module crm_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        pready
);
    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // accept input whenever the output side is free
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    // stall input while a result waits
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken during output stall");
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind corner_response_measure crm_port_checks u_crm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .pready(pready)
);

### bench/crm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_checker: response predictor and scoreboard for the corner measure
// Mirrors register writes from the configuration port, predicts the response
// of every pixel item taken on the input stream and compares each output
// item with the oldest prediction.
// ----------------------------------------------------------------------------
module crm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // coef_a, coef_b, coef_c
    input  logic        s_axis_tlast,   // last_pixel
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // response
    input  logic        m_axis_tlast,   // last_pixel_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    typedef struct packed {
        logic [47:0] response;
        logic        last;
    } t_corner_result;

    localparam logic signed [127:0] RespMax = (128'sd1 <<< 47) - 128'sd1;
    localparam logic signed [127:0] RespMin = -(128'sd1 <<< 47);

    t_corner_result   expected_resp_q[$];
    crm_pkg::t_mode   cur_mode;
    logic [15:0]      cur_k;
    logic [47:0]      cur_thresh;

    // Floor of the square root of a value below 2^52
    function automatic logic signed [127:0] isqrt_floor(logic signed [127:0] val);
        logic signed [127:0] root;
        logic signed [127:0] cand;
        root = 0;
        for (int i = 25; i >= 0; i--) begin
            cand = root | (128'sd1 <<< i);
            if (cand * cand <= val) root = cand;
        end
        return root;
    endfunction

    // Work out the thresholded, saturated measure of one pixel
    function automatic logic [47:0] predict_corner(logic [23:0] a, logic [23:0] b,
                                                   logic [23:0] c);
        logic signed [127:0] sa, sb, sc, tr, det, num, den, q, d, disc, r, th;
        logic                keep;
        sa  = $signed({104'd0, a});
        sc  = $signed({104'd0, c});
        sb  = $signed({{104{b[23]}}, b});
        tr  = sa + sc;
        det = sa * sc - sb * sb;
        th  = $signed({{80{cur_thresh[47]}}, cur_thresh});
        case (cur_mode)
            crm_pkg::MODE_HARMONIC: begin
                num = det <<< 1;
                den = tr + 128'sd1;
                q   = num / den;
                // round toward minus infinity
                if (num < 0 && q * den != num) q = q - 128'sd1;
                r    = q;
                keep = (r >= th);
            end
            crm_pkg::MODE_SHI: begin
                d    = (sa > sc) ? sa - sc : sc - sa;
                disc = d * d + 128'sd4 * sb * sb;
                r    = (tr - isqrt_floor(disc)) >>> 1;
                keep = (r > th);
            end
            default: begin
                r = ((det <<< 16) - $signed({112'd0, cur_k}) * tr * tr) >>> 24;
                keep = (r >= th);
            end
        endcase
        if (!keep) r = 0;
        if (r > RespMax) r = RespMax;
        else if (r < RespMin) r = RespMin;
        return r[47:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
    end

    assign o_pending = expected_resp_q.size();

    always @(posedge i_clk) begin
        t_corner_result want;
        if (!i_rst_n) begin
            cur_mode   <= crm_pkg::MODE_HARRIS;
            cur_k      <= 16'd3932;
            cur_thresh <= 48'd0;
            expected_resp_q.delete();
        end else begin
            // mirror register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    {crm_pkg::REG_MODE, 3'b000}:   cur_mode   <= crm_pkg::t_mode'(pwdata[1:0]);
                    {crm_pkg::REG_K, 3'b000}:      cur_k      <= pwdata[15:0];
                    {crm_pkg::REG_THRESH, 3'b000}: cur_thresh <= pwdata[47:0];
                    default: ;
                endcase
            end
            // predict each accepted pixel
            if (s_axis_tvalid && s_axis_tready) begin
                want.response = predict_corner(s_axis_tdata[23:0], s_axis_tdata[47:24],
                                               s_axis_tdata[71:48]);
                want.last     = s_axis_tlast;
                expected_resp_q = {expected_resp_q, want};
            end
            // compare each accepted response
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_resp_q.size() == 0) begin
                    report_mismatch("response item with nothing expected");
                end else begin
                    want = expected_resp_q.pop_front();
                    o_checked++;
                    if (m_axis_tdata !== want.response)
                        report_mismatch($sformatf("response got %h want %h",
                                                  m_axis_tdata, want.response));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last got %b want %b",
                                                  m_axis_tlast, want.last));
                end
            end
        end
    end
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the corner response measure
// Drives directed and random tensor items in all measure modes and register
// settings, with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // coef_a, coef_b, coef_c
    logic        s_axis_tlast = 1'b0; // last_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // response
    logic        m_axis_tlast;        // last_pixel_out
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    int fail_count, pending, checked;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit stall_req = 0;
    int phase_count = 0;

    corner_response_measure i_dut (.*);

    crm_checker i_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        static bit stall_taken = 0;
        static int stall_left = 0;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_req && !stall_taken) begin
                stall_taken = 1;
                stall_left  = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one pixel item and hold it until taken
    task automatic send_pixel(logic [23:0] a, logic [23:0] b, logic [23:0] c, logic last);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c, b, a};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, drain every expected result and let the pipeline settle
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    function automatic logic [47:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return 48'h8000_0000_0000;
            1: return 48'h7FFF_FFFF_FFFF;
            2: return 48'd0;
            3: return 48'(-$signed({1'b0, $urandom_range(0, 1 << 20)}));
            4: return 48'({$urandom, $urandom});
            default: return 48'($urandom_range(0, 1 << 24));
        endcase
    endfunction

    function automatic logic [23:0] pick_coef(bit signed_b);
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 4095)) ^ (signed_b && $urandom_range(0, 1)
                                                      ? 24'hFFFFFF : 24'h0);
            1: return 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes in every mode, Shi-Tomasi threshold equality
        for (int m = 0; m < 4; m++) begin
            write_reg(crm_pkg::REG_MODE, 64'(m));
            send_pixel(24'd0, 24'd0, 24'd0, 1'b0);
            send_pixel(24'hFFFFFF, 24'h800000, 24'hFFFFFF, 1'b0);
            send_pixel(24'hFFFFFF, 24'h7FFFFF, 24'h000000, 1'b1);
            send_pixel(24'h000000, 24'h7FFFFF, 24'hFFFFFF, 1'b0);
            send_pixel(24'd256, 24'd0, 24'd256, 1'b1);
            drain_pipeline();
        end
        write_reg(crm_pkg::REG_K, 64'd65535);
        write_reg(crm_pkg::REG_THRESH, 64'h8000_0000_0000);
        write_reg(crm_pkg::REG_MODE, 64'(crm_pkg::MODE_HARRIS));
        send_pixel(24'hFFFFFF, 24'h000000, 24'h000000, 1'b0);
        send_pixel(24'h123456, 24'hFEDCBA, 24'h654321, 1'b1);
        drain_pipeline();
        write_reg(crm_pkg::REG_THRESH, 64'd512);
        write_reg(crm_pkg::REG_MODE, 64'(crm_pkg::MODE_SHI));
        send_pixel(24'd512, 24'd0, 24'd512, 1'b0);   // response equals threshold
        send_pixel(24'd514, 24'd0, 24'd514, 1'b0);
        drain_pipeline();

        // Random phases with fresh register settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(crm_pkg::REG_MODE, 64'($urandom_range(0, 3)));
            write_reg(crm_pkg::REG_K, (ph == 2) ? 64'd0 : (ph == 5) ? 64'd65535
                                              : 64'($urandom_range(0, 65535)));
            write_reg(crm_pkg::REG_THRESH, 64'(pick_threshold()));
            if (ph < 3) begin
                send_idle_pct = 20;
                recv_idle_pct = 55;
            end else if (ph < 6) begin
                send_idle_pct = 55;
                recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 1) stall_req = 1;
            for (int n = 0; n < 240; n++)
                send_pixel(pick_coef(0), pick_coef(1), pick_coef(0),
                           ($urandom_range(0, 15) == 0));
            drain_pipeline();
            phase_count++;
        end

        $display("Covered %0d responses over %0d random phases in all four mode codes,",
                 checked, phase_count);
        $display("with extreme gains and thresholds, idling on both streams and a long stall.");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
